### src/one_wire_bus_master_defines.svh
// Assertion macros shared by the one_wire_bus_master RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWBM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("one_wire_bus_master: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OWBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("one_wire_bus_master: next-cycle check failed");

`endif

### src/owbm_pkg.sv
// Package of the one_wire_bus_master block: payload structs, command and
// phase codes, register indexes and reset values. No dependencies.
package owbm_pkg;

  localparam int unsigned TimerW       = 10;
  localparam int unsigned BitsPerByte  = 8;
  localparam int unsigned BitIdxW      = $clog2(BitsPerByte);
  localparam logic [TimerW-1:0] ReadSlotUs = TimerW'(96);
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW      = 3;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_WRITE    = 3'd4,
    PH_READ     = 3'd5
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESET_LOW       = 3'd0,
    CFG_PRESENCE_SAMPLE = 3'd1,
    CFG_RESET_TAIL      = 3'd2,
    CFG_WRITE_ONE_LOW   = 3'd3,
    CFG_WRITE_ZERO_LOW  = 3'd4,
    CFG_WRITE_SLOT      = 3'd5,
    CFG_READ_LOW        = 3'd6,
    CFG_READ_SAMPLE     = 3'd7
  } cfg_reg_e;

  localparam logic [TimerW-1:0] RstResetLow       = TimerW'(500);
  localparam logic [TimerW-1:0] RstPresenceSample = TimerW'(30);
  localparam logic [TimerW-1:0] RstResetTail      = TimerW'(300);
  localparam logic [TimerW-1:0] RstWriteOneLow    = TimerW'(5);
  localparam logic [TimerW-1:0] RstWriteZeroLow   = TimerW'(60);
  localparam logic [TimerW-1:0] RstWriteSlot      = TimerW'(85);
  localparam logic [TimerW-1:0] RstReadLow        = TimerW'(3);
  localparam logic [TimerW-1:0] RstReadSample     = TimerW'(8);

  typedef struct packed {
    logic       tick;
    logic       line_in;
    logic       start_req;
    logic [1:0] mode;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
  } out_item_t;

  // A classified item as it waits in the queue between front and back.
  typedef struct packed {
    logic       tick;
    logic       line_in;
    logic       start_ok;
    mode_e      kind;
    logic [7:0] write_byte;
  } cmd_t;

  typedef struct packed {
    logic [TimerW-1:0] reset_low_us;
    logic [TimerW-1:0] presence_sample_us;
    logic [TimerW-1:0] reset_tail_us;
    logic [TimerW-1:0] write_one_low_us;
    logic [TimerW-1:0] write_zero_low_us;
    logic [TimerW-1:0] write_slot_us;
    logic [TimerW-1:0] read_low_us;
    logic [TimerW-1:0] read_sample_us;
  } cfg_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### src/owbm_front.sv
// Front end of the one_wire_bus_master: takes input transfers and classifies
// the start request into a queue entry. Depends on owbm_pkg.
module owbm_front (
  input  owbm_pkg::in_item_t    in_i,
  input  logic                  in_valid_i,
  input  owbm_pkg::queue_stat_t stat_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output owbm_pkg::cmd_t        cmd_o
);

  assign in_stall_o = stat_i.full;
  assign push_o     = in_valid_i && !stat_i.full;

  always_comb begin
    cmd_o.tick       = in_i.tick;
    cmd_o.line_in    = in_i.line_in;
    cmd_o.write_byte = in_i.write_byte;
    unique case (in_i.mode)
      owbm_pkg::MODE_RESET: begin
        cmd_o.kind     = owbm_pkg::MODE_RESET;
        cmd_o.start_ok = in_i.start_req;
      end
      owbm_pkg::MODE_WRITE: begin
        cmd_o.kind     = owbm_pkg::MODE_WRITE;
        cmd_o.start_ok = in_i.start_req;
      end
      owbm_pkg::MODE_READ: begin
        cmd_o.kind     = owbm_pkg::MODE_READ;
        cmd_o.start_ok = in_i.start_req;
      end
      default: begin
        // The unused mode code never starts a command.
        cmd_o.kind     = owbm_pkg::MODE_NONE;
        cmd_o.start_ok = 1'b0;
      end
    endcase
  end

endmodule

### src/owbm_queue.sv
// Two-entry queue of classified items between the front and the back of
// the one_wire_bus_master. Depends on owbm_pkg.
module owbm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  owbm_pkg::cmd_t        cmd_i,
  input  logic                  pop_i,
  output owbm_pkg::cmd_t        cmd_o,
  output owbm_pkg::queue_stat_t stat_o
);

  owbm_pkg::cmd_t                      mem_q [owbm_pkg::QueueDepth];
  logic [owbm_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [owbm_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [owbm_pkg::QueueCntW-1:0]      cnt_q, cnt_d;

  localparam logic [owbm_pkg::QueuePtrW-1:0] LastPtr =
    owbm_pkg::QueuePtrW'(owbm_pkg::QueueDepth - 1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + owbm_pkg::QueueCntW'(push_i) - owbm_pkg::QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == owbm_pkg::QueueCntW'(owbm_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

### src/owbm_back.sv
// Back end of the one_wire_bus_master: the bus phase sequencer, slot timer,
// bit shifter and the output register. Depends on owbm_pkg.
module owbm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  owbm_pkg::cfg_t        cfg_i,
  input  owbm_pkg::cmd_t        cmd_i,
  input  owbm_pkg::queue_stat_t stat_i,
  output logic                  pop_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output owbm_pkg::out_item_t   out_o
);

  owbm_pkg::phase_e                   phase_q, phase_d;
  logic [owbm_pkg::TimerW-1:0]        timer_q, timer_d;
  logic [owbm_pkg::BitIdxW-1:0]       bit_q, bit_d;
  logic [7:0]                         shift_q, shift_d;
  logic                               pres_q, pres_d;
  logic [7:0]                         last_q, last_d;
  logic                               done;
  logic [owbm_pkg::TimerW-1:0]        t_next;
  logic [owbm_pkg::TimerW-1:0]        sample_pt;
  logic                               last_bit;
  logic                               out_valid_q;
  owbm_pkg::out_item_t                out_q, res;

  localparam logic [owbm_pkg::BitIdxW-1:0] LastBit =
    owbm_pkg::BitIdxW'(owbm_pkg::BitsPerByte - 1);

  // A new item is taken whenever the queue holds one and the output register is free or drains now.
  assign pop_o = !stat_i.empty && (!out_valid_q || !out_stall_i);

  assign t_next   = timer_q + 1'b1;
  assign last_bit = (bit_q == LastBit);

  always_comb begin
    sample_pt = (cfg_i.read_sample_us < owbm_pkg::ReadSlotUs) ?
                cfg_i.read_sample_us : owbm_pkg::ReadSlotUs;
    if (sample_pt == '0) begin
      sample_pt = owbm_pkg::TimerW'(1);
    end
  end

  // Next state of the sequencer and its datapath.
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    last_d  = last_q;
    done    = 1'b0;
    if (pop_o) begin
      if (phase_q == owbm_pkg::PH_IDLE) begin
        if (cmd_i.start_ok) begin
          timer_d = '0;
          bit_d   = '0;
          shift_d = (cmd_i.kind == owbm_pkg::MODE_WRITE) ? cmd_i.write_byte : 8'h00;
          unique case (cmd_i.kind)
            owbm_pkg::MODE_RESET: phase_d = owbm_pkg::PH_RST_LOW;
            owbm_pkg::MODE_WRITE: phase_d = owbm_pkg::PH_WRITE;
            default:              phase_d = owbm_pkg::PH_READ;
          endcase
        end
      end else if (cmd_i.tick) begin
        timer_d = t_next;
        unique case (phase_q)
          owbm_pkg::PH_RST_LOW: begin
            if (t_next >= cfg_i.reset_low_us) begin
              phase_d = owbm_pkg::PH_RST_WAIT;
              timer_d = '0;
            end
          end
          owbm_pkg::PH_RST_WAIT: begin
            if (t_next >= cfg_i.presence_sample_us) begin
              pres_d  = !cmd_i.line_in;
              phase_d = owbm_pkg::PH_RST_TAIL;
              timer_d = '0;
            end
          end
          owbm_pkg::PH_RST_TAIL: begin
            if (t_next >= cfg_i.reset_tail_us) begin
              phase_d = owbm_pkg::PH_IDLE;
              timer_d = '0;
              done    = 1'b1;
            end
          end
          owbm_pkg::PH_WRITE: begin
            if (t_next >= cfg_i.write_slot_us) begin
              shift_d = {1'b0, shift_q[7:1]};
              timer_d = '0;
              if (last_bit) begin
                phase_d = owbm_pkg::PH_IDLE;
                bit_d   = '0;
                done    = 1'b1;
              end else begin
                bit_d = bit_q + 1'b1;
              end
            end
          end
          owbm_pkg::PH_READ: begin
            if (t_next == sample_pt) begin
              shift_d = {cmd_i.line_in, shift_q[7:1]};
            end
            if (t_next >= owbm_pkg::ReadSlotUs) begin
              timer_d = '0;
              if (last_bit) begin
                last_d  = shift_d;
                phase_d = owbm_pkg::PH_IDLE;
                bit_d   = '0;
                done    = 1'b1;
              end else begin
                bit_d = bit_q + 1'b1;
              end
            end
          end
          default: begin
            phase_d = owbm_pkg::PH_IDLE;
            timer_d = '0;
          end
        endcase
      end
    end
  end

  // Result of the item, taken from the state after its update.
  always_comb begin
    res.busy_res  = (phase_d != owbm_pkg::PH_IDLE);
    res.done_res  = done;
    res.presence  = pres_d;
    res.read_byte = last_d;
    unique case (phase_d)
      owbm_pkg::PH_RST_LOW: res.drive_low = 1'b1;
      owbm_pkg::PH_WRITE:   res.drive_low = timer_d < (shift_d[0] ? cfg_i.write_one_low_us
                                                                  : cfg_i.write_zero_low_us);
      owbm_pkg::PH_READ:    res.drive_low = timer_d < cfg_i.read_low_us;
      default:              res.drive_low = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= owbm_pkg::PH_IDLE;
      timer_q     <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      pres_q      <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      last_q  <= last_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### src/one_wire_bus_master.sv
// Top level of the 1-Wire bus master: timing registers, front end, queue and
// back end. Depends on owbm_pkg, owbm_front, owbm_queue, owbm_back and the
// assertion macros in one_wire_bus_master_defines.svh.
//
// Each input transfer is one sampled clock of the bus: a one-microsecond tick
// strobe, the line level and an optional start of a reset/presence, write-byte
// or read-byte command. Each input transfer yields exactly one output transfer
// that shows the open-drain drive level, busy, a one-transfer done pulse, the
// presence flag of the last reset (1 means a device answered) and the last
// byte read; bytes travel least significant bit first. The block sustains one
// transfer per clock in both directions while the output side is not stalled.
// An accepted item is held in the two-entry queue and is turned into its result
// by the back end's update, which is registered in the output register.
// The queue is what sets the input stall: it rises only when both entries are
// held because the output side is stalled. The eight timing registers are
// written through a plain write port and must only change while no transfer
// is in flight; the read slot length is fixed at 96 ticks.

`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  owbm_pkg::in_item_t                  in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output owbm_pkg::out_item_t                 out_o,
  input  logic                                cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [owbm_pkg::TimerW-1:0]         cfg_wdata_i
);

  owbm_pkg::cfg_t        cfg_q, cfg_d;
  owbm_pkg::cmd_t        front_cmd;
  owbm_pkg::cmd_t        queue_cmd;
  owbm_pkg::queue_stat_t queue_stat;
  logic                  push;
  logic                  pop;

  // Timing register decode. Every index addresses one register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        owbm_pkg::CFG_RESET_LOW:       cfg_d.reset_low_us       = cfg_wdata_i;
        owbm_pkg::CFG_PRESENCE_SAMPLE: cfg_d.presence_sample_us = cfg_wdata_i;
        owbm_pkg::CFG_RESET_TAIL:      cfg_d.reset_tail_us      = cfg_wdata_i;
        owbm_pkg::CFG_WRITE_ONE_LOW:   cfg_d.write_one_low_us   = cfg_wdata_i;
        owbm_pkg::CFG_WRITE_ZERO_LOW:  cfg_d.write_zero_low_us  = cfg_wdata_i;
        owbm_pkg::CFG_WRITE_SLOT:      cfg_d.write_slot_us      = cfg_wdata_i;
        owbm_pkg::CFG_READ_LOW:        cfg_d.read_low_us        = cfg_wdata_i;
        owbm_pkg::CFG_READ_SAMPLE:     cfg_d.read_sample_us     = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us       <= owbm_pkg::RstResetLow;
      cfg_q.presence_sample_us <= owbm_pkg::RstPresenceSample;
      cfg_q.reset_tail_us      <= owbm_pkg::RstResetTail;
      cfg_q.write_one_low_us   <= owbm_pkg::RstWriteOneLow;
      cfg_q.write_zero_low_us  <= owbm_pkg::RstWriteZeroLow;
      cfg_q.write_slot_us      <= owbm_pkg::RstWriteSlot;
      cfg_q.read_low_us        <= owbm_pkg::RstReadLow;
      cfg_q.read_sample_us     <= owbm_pkg::RstReadSample;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end accepts transfers while the queue has room.
  owbm_front u_front (
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .stat_i     (queue_stat),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  owbm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (queue_cmd),
    .stat_o (queue_stat)
  );

  // The back end runs the bus phases and owns the output register.
  owbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (queue_cmd),
    .stat_i      (queue_stat),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // A finishing command never reports itself as still busy.
  `OWBM_ASSERT_SAME(a_done_not_busy, out_valid_o && out_o.done_res, !out_o.busy_res)
  // The line is only pulled low while a command runs.
  `OWBM_ASSERT_SAME(a_drive_needs_busy, out_valid_o && out_o.drive_low, out_o.busy_res)
  // The back end never takes an item from an empty queue.
  `OWBM_ASSERT_SAME(a_pop_not_empty, pop, !queue_stat.empty)
  // A write to the reset low-time register lands in that register.
  `OWBM_ASSERT_NEXT(a_cfg_write, cfg_we_i && (cfg_idx_i == owbm_pkg::CFG_RESET_LOW), cfg_q.reset_low_us == $past(cfg_wdata_i))

endmodule

### tb/one_wire_bus_master_tb.sv
// Self-checking testbench of the one_wire_bus_master block: drives tick, line and command
// transfers, predicts every result transfer with a cycle model and compares them field by field.
// Depends on owbm_pkg and the one_wire_bus_master RTL.
module one_wire_bus_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owbm_pkg::*;

  // How the bus line is driven while a command runs.
  localparam int LineLow    = 0;
  localparam int LineHigh   = 1;
  localparam int LineRandom = 2;

  // Least number of items per random traffic phase.
  localparam int PhaseItems = 20;

  // Item count that lets a command run to its end.
  localparam int unsigned NoItemLimit = 32'hFFFF_FFFF;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [TimerW-1:0]   cfg_wdata = '0;

  // Idle rates in percent: the sender leaves a cycle empty, the receiver stalls a cycle.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_items = 0;
  int unsigned mismatches = 0;

  // Cycle model of the bus master, advanced once per accepted input transfer.
  cfg_t               timing = '{RstResetLow, RstPresenceSample, RstResetTail, RstWriteOneLow,
                                 RstWriteZeroLow, RstWriteSlot, RstReadLow, RstReadSample};
  phase_e             bus_phase = PH_IDLE;
  logic [TimerW-1:0]  slot_cnt = '0;
  logic [BitIdxW-1:0] bit_pos = '0;
  logic [7:0]         shift_reg = '0;
  logic               presence_q = 1'b0;
  logic [7:0]         last_read_q = '0;

  // Bus status words that the block still owes, oldest first.
  out_item_t bus_status_fifo[$];

  one_wire_bus_master dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Applies one sampled clock of the bus to the model and queues the status it leads to.
  function automatic void advance_bus_master(in_item_t it);
    logic [TimerW-1:0] t;
    logic [TimerW-1:0] sample_at;
    logic [TimerW-1:0] low_len;
    logic              finished;
    out_item_t         res;
    finished = 1'b0;
    if (bus_phase == PH_IDLE) begin
      // An unused mode code leaves the block idle.
      if (it.start_req && mode_e'(it.mode) != MODE_NONE) begin
        slot_cnt = '0;
        bit_pos = '0;
        shift_reg = (mode_e'(it.mode) == MODE_WRITE) ? it.write_byte : 8'h00;
        case (mode_e'(it.mode))
          MODE_RESET: bus_phase = PH_RST_LOW;
          MODE_WRITE: bus_phase = PH_WRITE;
          default:    bus_phase = PH_READ;
        endcase
      end
    end else if (it.tick) begin
      t = slot_cnt + 1'b1;
      slot_cnt = t;
      case (bus_phase)
        PH_RST_LOW: begin
          if (t >= timing.reset_low_us) begin
            bus_phase = PH_RST_WAIT;
            slot_cnt = '0;
          end
        end
        PH_RST_WAIT: begin
          // A device answers by holding the line low at the sample point.
          if (t >= timing.presence_sample_us) begin
            presence_q = ~it.line_in;
            bus_phase = PH_RST_TAIL;
            slot_cnt = '0;
          end
        end
        PH_RST_TAIL: begin
          if (t >= timing.reset_tail_us) begin
            bus_phase = PH_IDLE;
            slot_cnt = '0;
            finished = 1'b1;
          end
        end
        PH_WRITE: begin
          if (t >= timing.write_slot_us) begin
            shift_reg = shift_reg >> 1;
            slot_cnt = '0;
            if (bit_pos == BitIdxW'(BitsPerByte - 1)) begin
              bus_phase = PH_IDLE;
              bit_pos = '0;
              finished = 1'b1;
            end else begin
              bit_pos = bit_pos + 1'b1;
            end
          end
        end
        PH_READ: begin
          // A sample point at or past the slot end falls on the slot's last tick.
          sample_at = (timing.read_sample_us < ReadSlotUs) ? timing.read_sample_us : ReadSlotUs;
          if (sample_at == '0) begin
            sample_at = TimerW'(1);
          end
          if (t == sample_at) begin
            shift_reg = {it.line_in, shift_reg[7:1]};
          end
          if (t >= ReadSlotUs) begin
            slot_cnt = '0;
            if (bit_pos == BitIdxW'(BitsPerByte - 1)) begin
              last_read_q = shift_reg;
              bus_phase = PH_IDLE;
              bit_pos = '0;
              finished = 1'b1;
            end else begin
              bit_pos = bit_pos + 1'b1;
            end
          end
        end
        default: begin
          bus_phase = PH_IDLE;
          slot_cnt = '0;
        end
      endcase
    end

    res.drive_low = 1'b0;
    case (bus_phase)
      PH_RST_LOW: res.drive_low = 1'b1;
      PH_WRITE: begin
        low_len = shift_reg[0] ? timing.write_one_low_us : timing.write_zero_low_us;
        res.drive_low = (slot_cnt < low_len);
      end
      PH_READ: res.drive_low = (slot_cnt < timing.read_low_us);
      default: ;
    endcase
    res.busy_res = (bus_phase != PH_IDLE);
    res.done_res = finished;
    res.presence = presence_q;
    res.read_byte = last_read_q;
    bus_status_fifo.push_back(res);
  endfunction

  // Offers one item, with random empty cycles ahead of it, and holds it until it is taken.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sent_items++;
    advance_bus_master(it);
  endtask

  // Sends the item that starts one command; its tick and line are random.
  task automatic start_command(mode_e cmd, logic [7:0] wbyte);
    in_item_t it;
    it = in_item_t'(13'($urandom));
    it.start_req = 1'b1;
    it.mode = cmd;
    it.write_byte = wbyte;
    send_item(it);
  endtask

  // Keeps the bus clocked while the model sees a command running, for at most max_items
  // items. Stray starts with random modes are mixed in; the block must ignore them.
  task automatic clock_command(int line_sel, int unsigned tick_pct, int unsigned max_items);
    in_item_t    it;
    int unsigned n;
    n = 0;
    while (bus_phase != PH_IDLE && n < max_items) begin
      it.tick = ($urandom_range(99) < tick_pct);
      case (line_sel)
        LineLow:  it.line_in = 1'b0;
        LineHigh: it.line_in = 1'b1;
        default:  it.line_in = 1'($urandom_range(1));
      endcase
      it.start_req = ($urandom_range(99) < 3);
      it.mode = 2'($urandom_range(3));
      it.write_byte = 8'($urandom_range(255));
      send_item(it);
      n++;
    end
  endtask

  // Starts one command and keeps the bus clocked until the model sees it finish.
  task automatic run_command(mode_e cmd, logic [7:0] wbyte, int line_sel, int unsigned tick_pct);
    start_command(cmd, wbyte);
    clock_command(line_sel, tick_pct, NoItemLimit);
  endtask

  // Waits until every owed result has come out, then lets the pipeline settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (bus_status_fifo.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timing_reg(cfg_reg_e idx, logic [TimerW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Loads all eight slot timings once no transfer is in flight.
  task automatic program_timing(cfg_t c);
    drain_block();
    write_timing_reg(CFG_RESET_LOW, c.reset_low_us);
    write_timing_reg(CFG_PRESENCE_SAMPLE, c.presence_sample_us);
    write_timing_reg(CFG_RESET_TAIL, c.reset_tail_us);
    write_timing_reg(CFG_WRITE_ONE_LOW, c.write_one_low_us);
    write_timing_reg(CFG_WRITE_ZERO_LOW, c.write_zero_low_us);
    write_timing_reg(CFG_WRITE_SLOT, c.write_slot_us);
    write_timing_reg(CFG_READ_LOW, c.read_low_us);
    write_timing_reg(CFG_READ_SAMPLE, c.read_sample_us);
    cfg_we <= 1'b0;
    timing = c;
  endtask

  // Timings as they come out of reset: the first two slots of a write, a one bit and then a
  // zero bit, after which short slots finish the byte; a reset that samples presence at its
  // reset delay with a device answering; a start with the unused mode code.
  task automatic test_reset_timing();
    cfg_t c;
    start_command(MODE_WRITE, 8'h01);
    clock_command(LineRandom, 100, 2 * 32'(RstWriteSlot));
    c = timing;
    c.reset_low_us = TimerW'(4);
    c.reset_tail_us = TimerW'(5);
    c.write_one_low_us = TimerW'(1);
    c.write_zero_low_us = TimerW'(2);
    c.write_slot_us = TimerW'(3);
    program_timing(c);
    clock_command(LineRandom, 100, NoItemLimit);
    run_command(MODE_RESET, 8'h00, LineLow, 100);
    run_command(MODE_NONE, 8'h5A, LineRandom, 100);
  endtask

  // Every register at zero: each phase lasts a single tick.
  task automatic test_zero_lengths();
    program_timing('0);
    run_command(MODE_RESET, 8'hFF, LineHigh, 100);
    run_command(MODE_WRITE, 8'h00, LineRandom, 100);
    run_command(MODE_WRITE, 8'hFF, LineRandom, 100);
  endtask

  // Write low times at their maximum: the line stays low for every whole write slot.
  task automatic test_long_low_times();
    cfg_t c;
    c.reset_low_us = TimerW'(2);
    c.presence_sample_us = TimerW'(2);
    c.reset_tail_us = TimerW'(2);
    c.write_one_low_us = '1;
    c.write_zero_low_us = '1;
    c.write_slot_us = TimerW'(4);
    c.read_low_us = RstReadLow;
    c.read_sample_us = RstReadSample;
    program_timing(c);
    run_command(MODE_RESET, 8'h00, LineLow, 100);
    run_command(MODE_WRITE, 8'h81, LineRandom, 100);
  endtask

  // One read byte whose slot pairs run under their own read timing and idle rates: the
  // timings out of reset, low time and sample point beyond the slot, both at zero, and both
  // exactly at the slot length.
  task automatic test_read_slots();
    cfg_t c;
    c = timing;
    c.read_low_us = RstReadLow;
    c.read_sample_us = RstReadSample;
    program_timing(c);
    start_command(MODE_READ, 8'h00);
    clock_command(LineRandom, 100, 2 * 32'(ReadSlotUs));
    c.read_low_us = '1;
    c.read_sample_us = '1;
    program_timing(c);
    gap_pct = 86;
    clock_command(LineRandom, 100, 2 * 32'(ReadSlotUs));
    c.read_low_us = '0;
    c.read_sample_us = '0;
    program_timing(c);
    gap_pct = 0;
    stall_pct = 86;
    clock_command(LineRandom, 100, 2 * 32'(ReadSlotUs));
    c.read_low_us = ReadSlotUs;
    c.read_sample_us = ReadSlotUs;
    program_timing(c);
    gap_pct = 25;
    stall_pct = 25;
    clock_command(LineRandom, 100, NoItemLimit);
    drain_block();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  // Random timings and a random mix of commands, idle noise and stray starts.
  task automatic test_random_traffic(int unsigned send_gap, int unsigned recv_stall);
    cfg_t        c;
    in_item_t    it;
    int unsigned first_item;
    int unsigned pick;
    c.reset_low_us = TimerW'($urandom_range(8));
    c.presence_sample_us = TimerW'($urandom_range(8));
    c.reset_tail_us = TimerW'($urandom_range(8));
    c.write_one_low_us = TimerW'($urandom_range(8));
    c.write_zero_low_us = TimerW'($urandom_range(8));
    c.write_slot_us = TimerW'($urandom_range(6));
    c.read_low_us = TimerW'($urandom_range(10));
    c.read_sample_us = TimerW'($urandom_range(30));
    program_timing(c);
    gap_pct = send_gap;
    stall_pct = recv_stall;
    first_item = sent_items;
    while (sent_items - first_item < PhaseItems) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // Idle noise: items with no start, then a start with the unused mode code.
        repeat ($urandom_range(4, 1)) begin
          it = in_item_t'(13'($urandom));
          it.start_req = 1'b0;
          send_item(it);
        end
        run_command(MODE_NONE, 8'($urandom_range(255)), LineRandom, 80);
      end else if (pick < 50) begin
        run_command(MODE_RESET, 8'($urandom_range(255)), LineRandom, 85);
      end else begin
        run_command(MODE_WRITE, 8'($urandom_range(255)), LineRandom, 85);
      end
    end
    drain_block();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  task automatic compare_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Output side: every result transfer is checked against the oldest owed status word,
  // and the stall for the next cycle is drawn.
  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_status_fifo.size() == 0) begin
        $display("%0t: result %h with none expected", $time, out_item);
        mismatches++;
      end else begin
        exp = bus_status_fifo.pop_front();
        compare_field("drive_low", exp.drive_low, out_item.drive_low);
        compare_field("busy_res", exp.busy_res, out_item.busy_res);
        compare_field("done_res", exp.done_res, out_item.done_res);
        compare_field("presence", exp.presence, out_item.presence);
        compare_field("read_byte", exp.read_byte, out_item.read_byte);
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_timing();
    test_zero_lengths();
    test_long_low_times();
    test_read_slots();
    test_random_traffic(0, 0);
    test_random_traffic(86, 0);
    test_random_traffic(0, 86);
    test_random_traffic(25, 25);
    drain_block();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS one_wire_bus_master");
    end else begin
      $display("FAIL one_wire_bus_master");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAIL one_wire_bus_master");
    $finish;
  end

endmodule
